// ===== rtl/tulc_pkg.sv =====
package tulc_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int COMMAND_COUNT_DEF = 40;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_RX    = 2'd1;
  localparam logic [1:0] ACT_READY = 2'd2;
  localparam logic [1:0] ACT_QUEUE = 2'd3;

  localparam logic [2:0] REG_STARTUP    = 3'd0;
  localparam logic [2:0] REG_GAP        = 3'd1;
  localparam logic [2:0] REG_TX_TO      = 3'd2;
  localparam logic [2:0] REG_RX_TO      = 3'd3;
  localparam logic [2:0] REG_LOST       = 3'd4;
  localparam logic [2:0] REG_FIRST_LOST = 3'd5;

  localparam logic [7:0] FRAME_START = 8'hF5;
  localparam logic [7:0] TYPE_LOW    = 8'hFA;
  localparam logic [7:0] TYPE_MUTED  = 8'hFD;
  localparam logic [5:0] MUTE_INDEX  = 6'd3;
  localparam logic [5:0] TYPE_QUERY  = 6'd39;
  localparam logic [2:0] FRAME_LEN   = 3'd5;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [5:0] command;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       reply_done;
    logic       power_on;
    logic [7:0] tuner_type;
    logic       tx_busy;
    logic       connected;
    logic       checksum_error;
    logic       rx_timeout_seen;
    logic       link_lost;
    logic       command_accepted;
  } out_item_t;

  // classified event handed from front to back
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [5:0] command;
    logic       cmd_ok;
  } event_t;

  function automatic logic [23:0] rom_row(input logic [5:0] cmd);
    case (cmd)
      6'd0:  rom_row = "PON";  6'd1:  rom_row = "POF";  6'd2:  rom_row = "SRC";
      6'd3:  rom_row = "MUT";  6'd4:  rom_row = "MEM";  6'd5:  rom_row = "ENT";
      6'd6:  rom_row = "EXT";  6'd7:  rom_row = "ALT";  6'd8:  rom_row = "ART";
      6'd9:  rom_row = "CUP";  6'd10: rom_row = "CDN";  6'd11: rom_row = "000";
      6'd12: rom_row = "001";  6'd13: rom_row = "002";  6'd14: rom_row = "003";
      6'd15: rom_row = "004";  6'd16: rom_row = "005";  6'd17: rom_row = "006";
      6'd18: rom_row = "007";  6'd19: rom_row = "008";  6'd20: rom_row = "009";
      6'd21: rom_row = "100";  6'd22: rom_row = "RTN";  6'd23: rom_row = "CCD";
      6'd24: rom_row = "APT";  6'd25: rom_row = "VCP";  6'd26: rom_row = "CBS";
      6'd27: rom_row = "SVO";  6'd28: rom_row = "CMP";  6'd29: rom_row = "VGA";
      6'd30: rom_row = "TNR";  6'd31: rom_row = "HDM";  6'd32: rom_row = "STA";
      6'd33: rom_row = "EPG";  6'd34: rom_row = "TXT";  6'd35: rom_row = "RED";
      6'd36: rom_row = "GRE";  6'd37: rom_row = "YEL";  6'd38: rom_row = "BLU";
      6'd39: rom_row = "ADI";
      default: rom_row = 24'd0;
    endcase
  endfunction

endpackage

// ===== rtl/tulc_front.sv =====
module tulc_front #(
  parameter int COMMAND_COUNT = tulc_pkg::COMMAND_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tulc_pkg::in_item_t in_data,
  output logic               ev_valid,
  input  logic               ev_stall,
  output tulc_pkg::event_t   ev_data
);

  // two-entry skid queue
  tulc_pkg::event_t q [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop  = ev_valid && !ev_stall;
  assign ev_valid = (count != 2'd0);
  assign ev_data  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].action  <= in_data.action;
      q[wr_ptr].rx_byte <= in_data.rx_byte;
      q[wr_ptr].command <= in_data.command;
      q[wr_ptr].cmd_ok  <= ({26'd0, in_data.command} < COMMAND_COUNT);
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !pop |=> count == 2'd2) else $error("skid overflow");
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    ev_valid == (count != 2'd0)) else $error("valid mismatch");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1) else $error("count slip");

endmodule

// ===== rtl/tulc_back.sv =====
module tulc_back #(
  parameter int QUEUE_DEPTH = tulc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                ev_valid,
  output logic                ev_stall,
  input  tulc_pkg::event_t    ev_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tulc_pkg::out_item_t out_data
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [15:0] startup_delay, send_gap, lost_time, first_lost_time;
  logic [7:0]  tx_timeout, rx_timeout;

  logic [1:0] rx_phase, rx_phase_next;
  logic [7:0] rx_status, rx_status_next, rx_code, rx_code_next;
  logic       rx_pending, rx_pending_next, rx_in_frame, rx_in_frame_next;
  logic [7:0] rx_timer, rx_timer_next;
  logic [5:0] tx_command, tx_command_next, last_sent, last_sent_next;
  logic [2:0] tx_position, tx_position_next;
  logic       tx_active, tx_active_next;
  logic [7:0] tx_timer, tx_timer_next;
  logic [15:0] gap_timer, gap_timer_next, startup_timer, startup_timer_next;
  logic [15:0] silence_timer, silence_timer_next;
  logic       f_conn, f_conn_next, f_csum, f_csum_next, f_rxto, f_rxto_next;
  logic       f_lost, f_lost_next;
  logic [7:0] tuner, tuner_next;
  logic       power, power_next;
  logic [QW-1:0] head, head_next, tail;
  logic [CW-1:0] count, count_next;

  logic [5:0] mem [QUEUE_DEPTH];
  logic [5:0] head_cmd;
  logic       do_push;

  logic fire;
  assign ev_stall = out_valid && out_stall;
  assign fire = ev_valid && !ev_stall;

  // head entry is read through its own register, refreshed on every pointer move
  logic [5:0] q_read;
  logic [QW-1:0] rd_addr;
  logic       bypass;
  logic [5:0] bypass_cmd;

  assign head_cmd = bypass ? bypass_cmd : q_read;

  logic txv, done, accepted;
  logic [7:0] txb;
  logic [23:0] row;
  logic [15:0] limit;
  logic [7:0] rtmp;

  always_comb begin
    rx_phase_next = rx_phase; rx_status_next = rx_status; rx_code_next = rx_code;
    rx_pending_next = rx_pending; rx_in_frame_next = rx_in_frame;
    rx_timer_next = rx_timer; tx_command_next = tx_command; last_sent_next = last_sent;
    tx_position_next = tx_position; tx_active_next = tx_active; tx_timer_next = tx_timer;
    gap_timer_next = gap_timer; startup_timer_next = startup_timer;
    silence_timer_next = silence_timer; f_conn_next = f_conn; f_csum_next = f_csum;
    f_rxto_next = f_rxto; f_lost_next = f_lost; tuner_next = tuner; power_next = power;
    head_next = head; count_next = count;
    txv = 1'b0; txb = 8'd0; done = 1'b0; accepted = 1'b0; do_push = 1'b0;
    limit = f_conn ? lost_time : first_lost_time;
    rtmp = 8'd0;
    row = 24'd0;
    case (ev_data.action)
      tulc_pkg::ACT_TICK: begin
        if (tx_active) begin
          if (tx_timer > tx_timeout) begin
            tx_timer_next = 8'd0; tx_active_next = 1'b0;
          end else if (tx_timer != 8'hFF) tx_timer_next = tx_timer + 8'd1;
        end else tx_timer_next = 8'd0;
        if (rx_in_frame) begin
          rtmp = (rx_timer != 8'hFF) ? rx_timer + 8'd1 : rx_timer;
          rx_timer_next = rtmp;
          if (rtmp > rx_timeout) begin
            f_rxto_next = 1'b1; rx_in_frame_next = 1'b0; rx_phase_next = 2'd0;
          end
        end else rx_timer_next = 8'd0;
        if (gap_timer != 16'hFFFF) gap_timer_next = gap_timer + 16'd1;
        if (startup_timer != 16'hFFFF) startup_timer_next = startup_timer + 16'd1;
        if (silence_timer < limit) silence_timer_next = silence_timer + 16'd1;
        else f_lost_next = 1'b1;
        if (startup_timer_next >= startup_delay) begin
          if (rx_pending) begin
            if (last_sent == tulc_pkg::TYPE_QUERY && rx_code >= tulc_pkg::TYPE_LOW &&
                rx_code <= tulc_pkg::TYPE_MUTED)
              tuner_next = rx_code;
            power_next = rx_status[7];
            rx_status_next = 8'd0; rx_code_next = 8'd0; rx_pending_next = 1'b0;
            gap_timer_next = 16'd0;
            done = 1'b1;
          end
          if (gap_timer_next >= send_gap && count != '0) begin
            head_next = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
            count_next = count - 1'b1;
            last_sent_next = head_cmd; tx_command_next = head_cmd;
            tx_active_next = 1'b1; tx_timer_next = 8'd0; gap_timer_next = 16'd0;
            tx_position_next = 3'd1;
            txv = 1'b1; txb = tulc_pkg::FRAME_START;
          end
        end
      end
      tulc_pkg::ACT_RX: begin
        if (!rx_pending) begin
          case (rx_phase)
            2'd0: if (ev_data.rx_byte == tulc_pkg::FRAME_START) begin
              rx_in_frame_next = 1'b1; rx_timer_next = 8'd0; rx_phase_next = 2'd1;
            end
            2'd1: begin rx_status_next = ev_data.rx_byte; rx_phase_next = 2'd2; end
            2'd2: begin rx_code_next = ev_data.rx_byte; rx_phase_next = 2'd3; end
            default: begin
              rx_in_frame_next = 1'b0; rx_phase_next = 2'd0;
              if (tulc_pkg::FRAME_START + rx_status + rx_code == ev_data.rx_byte) begin
                f_lost_next = 1'b0; f_conn_next = 1'b1; rx_pending_next = 1'b1;
              end else f_csum_next = 1'b1;
            end
          endcase
        end
        silence_timer_next = 16'd0;
      end
      tulc_pkg::ACT_READY: begin
        row = tulc_pkg::rom_row(tx_command);
        if (tx_active && tx_position < tulc_pkg::FRAME_LEN) begin
          txv = 1'b1;
          tx_position_next = tx_position + 3'd1;
          case (tx_position)
            3'd0: txb = tulc_pkg::FRAME_START;
            3'd1: txb = row[23:16];
            3'd2: txb = row[15:8];
            3'd3: txb = row[7:0];
            default: txb = tulc_pkg::FRAME_START + row[23:16] + row[15:8] + row[7:0];
          endcase
        end else begin
          tx_position_next = 3'd0; tx_active_next = 1'b0;
        end
      end
      default: begin
        if (ev_data.cmd_ok && !(tuner == tulc_pkg::TYPE_MUTED &&
            ev_data.command == tulc_pkg::MUTE_INDEX) && count != CW'(QUEUE_DEPTH)) begin
          do_push = 1'b1; accepted = 1'b1; count_next = count + 1'b1;
        end
      end
    endcase
  end

  assign rd_addr = fire ? head_next : head;

  always_ff @(posedge clk) begin
    if (fire && do_push) mem[tail] <= ev_data.command;
    q_read <= mem[rd_addr];
    // a write to the entry being fetched is forwarded
    bypass <= fire && do_push && (tail == rd_addr);
    bypass_cmd <= ev_data.command;
    if (cfg_we) begin
      case (cfg_index)
        tulc_pkg::REG_STARTUP:    startup_delay   <= cfg_data;
        tulc_pkg::REG_GAP:        send_gap        <= cfg_data;
        tulc_pkg::REG_TX_TO:      tx_timeout      <= cfg_data[7:0];
        tulc_pkg::REG_RX_TO:      rx_timeout      <= cfg_data[7:0];
        tulc_pkg::REG_LOST:       lost_time       <= cfg_data;
        tulc_pkg::REG_FIRST_LOST: first_lost_time <= cfg_data;
        default: ;
      endcase
    end
    if (fire) begin
      out_data.tx_valid <= txv; out_data.tx_byte <= txb; out_data.reply_done <= done;
      out_data.power_on <= power_next; out_data.tuner_type <= tuner_next;
      out_data.tx_busy <= tx_active_next; out_data.connected <= f_conn_next;
      out_data.checksum_error <= f_csum_next; out_data.rx_timeout_seen <= f_rxto_next;
      out_data.link_lost <= f_lost_next; out_data.command_accepted <= accepted;
    end
    if (rst) begin
      startup_delay <= 16'd2000; send_gap <= 16'd250; tx_timeout <= 8'd50;
      rx_timeout <= 8'd50; lost_time <= 16'd5000; first_lost_time <= 16'd10000;
      rx_phase <= 2'd0; rx_status <= 8'd0; rx_code <= 8'd0; rx_pending <= 1'b0;
      rx_in_frame <= 1'b0; rx_timer <= 8'd0; tx_command <= 6'd0; last_sent <= 6'd0;
      tx_position <= 3'd0; tx_active <= 1'b0; tx_timer <= 8'd0; gap_timer <= 16'd0;
      startup_timer <= 16'd0; silence_timer <= 16'd0; f_conn <= 1'b0; f_csum <= 1'b0;
      f_rxto <= 1'b0; f_lost <= 1'b0; tuner <= 8'd0; power <= 1'b0;
      head <= '0; tail <= '0; count <= '0; out_valid <= 1'b0; bypass <= 1'b0;
    end else begin
      if (fire) begin
        rx_phase <= rx_phase_next; rx_status <= rx_status_next; rx_code <= rx_code_next;
        rx_pending <= rx_pending_next; rx_in_frame <= rx_in_frame_next;
        rx_timer <= rx_timer_next; tx_command <= tx_command_next; last_sent <= last_sent_next;
        tx_position <= tx_position_next; tx_active <= tx_active_next;
        tx_timer <= tx_timer_next; gap_timer <= gap_timer_next;
        startup_timer <= startup_timer_next; silence_timer <= silence_timer_next;
        f_conn <= f_conn_next; f_csum <= f_csum_next; f_rxto <= f_rxto_next;
        f_lost <= f_lost_next; tuner <= tuner_next; power <= power_next;
        head <= head_next; count <= count_next;
        if (do_push) tail <= (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (fire) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH)) else $error("queue count beyond depth");
  a_tx_needs_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.tx_valid |-> out_data.tx_busy) else $error("byte while idle");
  a_done_conn: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.reply_done |-> out_data.connected) else $error("reply unconnected");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

endmodule

// ===== rtl/tuner_uart_link_controller.sv =====
// Path: an accepted input transaction is registered in the front skid queue, then the back-end update
// registers its result in the output register; output stalls can hold it in between.
// Throughput: one transaction per cycle while the output is not stalled; the back end handles each event in one update.
// Reset: synchronous, active high; registers return to their defaults, timers and flags
// clear, the command queue comes up empty. No clearing pass is needed.
module tuner_uart_link_controller #(
  parameter int QUEUE_DEPTH   = tulc_pkg::QUEUE_DEPTH_DEF,
  parameter int COMMAND_COUNT = tulc_pkg::COMMAND_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tulc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tulc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  logic             ev_valid, ev_stall;
  tulc_pkg::event_t ev_data;

  tulc_front #(.COMMAND_COUNT(COMMAND_COUNT)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .ev_valid, .ev_stall, .ev_data
  );

  tulc_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst, .ev_valid, .ev_stall, .ev_data, .cfg_we, .cfg_index, .cfg_data,
    .out_valid, .out_stall, .out_data
  );

endmodule

// ===== dv/tulc_checker.sv =====
module tulc_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tulc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tulc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output int                  errors,
  output int                  waiting,
  output int                  n_replies,
  output int                  n_tx_bytes
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam string CODES = {"PONPOFSRCMUTMEMENTEXTALTARTCUPCDN000001002003004005",
                             "006007008009100RTNCCDAPTVCPCBSSVOCMPVGATNRHDMSTAEPG",
                             "TXTREDGREYELBLUADI"};
  localparam int CMD_COUNT = tulc_pkg::COMMAND_COUNT_DEF;
  localparam int CMD_SLOTS = tulc_pkg::QUEUE_DEPTH_DEF;

  // configuration copy
  logic [15:0] c_startup, c_gap, c_lost, c_first_lost;
  logic [7:0]  c_tx_to, c_rx_to;

  // link state
  logic [1:0]  rx_phase;
  logic [7:0]  rx_status, rx_code, rx_tmr, tx_tmr;
  logic        rx_pending, rx_in_frame, tx_act;
  logic [5:0]  tx_cmd, last_sent;
  logic [2:0]  tx_pos;
  logic [15:0] gap_tmr, startup_tmr, silence_tmr;
  logic        f_conn, f_csum, f_rxto, f_lost, power;
  logic [7:0]  tuner;
  logic [5:0]  cmd_fifo[$];

  tulc_pkg::out_item_t expected_results[$];

  function automatic logic [7:0] code_char(logic [5:0] cmd, int k);
    if (cmd >= CMD_COUNT) return 8'd0;
    return CODES[cmd * 3 + k];
  endfunction

  function automatic logic [7:0] frame_byte(logic [5:0] cmd, logic [2:0] pos);
    if (pos == 0) return tulc_pkg::FRAME_START;
    if (pos <= 3) return code_char(cmd, pos - 1);
    return tulc_pkg::FRAME_START + code_char(cmd, 0) + code_char(cmd, 1) + code_char(cmd, 2);
  endfunction

  task automatic emit_byte(output logic v, output logic [7:0] b);
    if (tx_act && tx_pos < tulc_pkg::FRAME_LEN) begin
      v = 1'b1;
      b = frame_byte(tx_cmd, tx_pos);
      tx_pos++;
    end else begin
      v = 1'b0;
      b = 8'd0;
      tx_pos = 0;
      tx_act = 1'b0;
    end
  endtask

  task automatic advance_link(input tulc_pkg::in_item_t it, output tulc_pkg::out_item_t r);
    logic [15:0] limit;
    logic        v;
    logic [7:0]  b;
    v = 1'b0;
    b = 8'd0;
    r = '0;
    case (it.action)
      tulc_pkg::ACT_TICK: begin
        if (tx_act) begin
          if (tx_tmr > c_tx_to) begin
            tx_tmr = 0;
            tx_act = 1'b0;
          end else if (tx_tmr < 8'hFF) begin
            tx_tmr++;
          end
        end else begin
          tx_tmr = 0;
        end
        if (rx_in_frame) begin
          if (rx_tmr < 8'hFF) rx_tmr++;
          if (rx_tmr > c_rx_to) begin
            f_rxto = 1'b1;
            rx_in_frame = 1'b0;
            rx_phase = 0;
          end
        end else begin
          rx_tmr = 0;
        end
        if (gap_tmr != 16'hFFFF) gap_tmr++;
        if (startup_tmr != 16'hFFFF) startup_tmr++;
        limit = f_conn ? c_lost : c_first_lost;
        if (silence_tmr < limit) silence_tmr++;
        else f_lost = 1'b1;
        if (startup_tmr >= c_startup) begin
          if (rx_pending) begin
            // tuner type only answers the type query
            if (last_sent == tulc_pkg::TYPE_QUERY && rx_code >= tulc_pkg::TYPE_LOW &&
                rx_code <= tulc_pkg::TYPE_MUTED)
              tuner = rx_code;
            power = rx_status[7];
            rx_status = 0;
            rx_code = 0;
            rx_pending = 1'b0;
            gap_tmr = 0;
            r.reply_done = 1'b1;
          end
          if (gap_tmr >= c_gap && cmd_fifo.size() > 0) begin
            tx_cmd = cmd_fifo.pop_front();
            last_sent = tx_cmd;
            tx_pos = 0;
            tx_act = 1'b1;
            tx_tmr = 0;
            gap_tmr = 0;
            emit_byte(v, b);
          end
        end
      end
      tulc_pkg::ACT_RX: begin
        if (!rx_pending) begin
          case (rx_phase)
            2'd0: if (it.rx_byte == tulc_pkg::FRAME_START) begin
              rx_in_frame = 1'b1;
              rx_tmr = 0;
              rx_phase = 1;
            end
            2'd1: begin
              rx_status = it.rx_byte;
              rx_phase = 2;
            end
            2'd2: begin
              rx_code = it.rx_byte;
              rx_phase = 3;
            end
            default: begin
              rx_in_frame = 1'b0;
              if (8'(tulc_pkg::FRAME_START + rx_status + rx_code) == it.rx_byte) begin
                f_lost = 1'b0;
                f_conn = 1'b1;
                rx_pending = 1'b1;
              end else begin
                f_csum = 1'b1;
              end
              rx_phase = 0;
            end
          endcase
        end
        silence_tmr = 0;
      end
      tulc_pkg::ACT_READY: emit_byte(v, b);
      default: begin
        if (it.command < CMD_COUNT &&
            !(tuner == tulc_pkg::TYPE_MUTED && it.command == tulc_pkg::MUTE_INDEX) &&
            cmd_fifo.size() < CMD_SLOTS) begin
          cmd_fifo.push_back(it.command);
          r.command_accepted = 1'b1;
        end
      end
    endcase
    r.tx_valid        = v;
    r.tx_byte         = b;
    r.power_on        = power;
    r.tuner_type      = tuner;
    r.tx_busy         = tx_act;
    r.connected       = f_conn;
    r.checksum_error  = f_csum;
    r.rx_timeout_seen = f_rxto;
    r.link_lost       = f_lost;
  endtask

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic compare_result(tulc_pkg::out_item_t got, tulc_pkg::out_item_t want);
    if (got.tx_valid != want.tx_valid) report("tx_valid", got.tx_valid, want.tx_valid);
    if (got.tx_byte != want.tx_byte) report("tx_byte", got.tx_byte, want.tx_byte);
    if (got.reply_done != want.reply_done) report("reply_done", got.reply_done, want.reply_done);
    if (got.power_on != want.power_on) report("power_on", got.power_on, want.power_on);
    if (got.tuner_type != want.tuner_type) report("tuner_type", got.tuner_type, want.tuner_type);
    if (got.tx_busy != want.tx_busy) report("tx_busy", got.tx_busy, want.tx_busy);
    if (got.connected != want.connected) report("connected", got.connected, want.connected);
    if (got.checksum_error != want.checksum_error)
      report("checksum_error", got.checksum_error, want.checksum_error);
    if (got.rx_timeout_seen != want.rx_timeout_seen)
      report("rx_timeout_seen", got.rx_timeout_seen, want.rx_timeout_seen);
    if (got.link_lost != want.link_lost) report("link_lost", got.link_lost, want.link_lost);
    if (got.command_accepted != want.command_accepted)
      report("command_accepted", got.command_accepted, want.command_accepted);
  endtask

  initial begin
    errors = 0;
    n_replies = 0;
    n_tx_bytes = 0;
  end

  assign waiting = expected_results.size();

  always @(posedge clk) begin
    tulc_pkg::out_item_t r;
    if (rst) begin
      c_startup = 16'd2000; c_gap = 16'd250; c_tx_to = 8'd50; c_rx_to = 8'd50;
      c_lost = 16'd5000; c_first_lost = 16'd10000;
      rx_phase = 0; rx_status = 0; rx_code = 0; rx_tmr = 0; tx_tmr = 0;
      rx_pending = 0; rx_in_frame = 0; tx_act = 0; tx_cmd = 0; last_sent = 0; tx_pos = 0;
      gap_tmr = 0; startup_tmr = 0; silence_tmr = 0;
      f_conn = 0; f_csum = 0; f_rxto = 0; f_lost = 0; power = 0; tuner = 0;
      cmd_fifo.delete();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected transaction", out_data, 0);
        end else begin
          compare_result(out_data, expected_results.pop_front());
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          tulc_pkg::REG_STARTUP:    c_startup = cfg_data;
          tulc_pkg::REG_GAP:        c_gap = cfg_data;
          tulc_pkg::REG_TX_TO:      c_tx_to = cfg_data[7:0];
          tulc_pkg::REG_RX_TO:      c_rx_to = cfg_data[7:0];
          tulc_pkg::REG_LOST:       c_lost = cfg_data;
          tulc_pkg::REG_FIRST_LOST: c_first_lost = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_link(in_data, r);
        if (r.reply_done) n_replies++;
        if (r.tx_valid) n_tx_bytes++;
        expected_results.push_back(r);
      end
    end
  end
endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tulc_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tulc_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = tulc_pkg::REG_STARTUP;
  logic [15:0]         cfg_data = '0;

  int errors, waiting, n_replies, n_tx_bytes;
  int cycles = 0;
  int n_items = 0;
  int n_phases = 0;
  int stall_left = 0;
  bit busy_mode = 1'b1;

  always #5 clk = ~clk;

  tuner_uart_link_controller u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  tulc_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .errors, .waiting, .n_replies, .n_tx_bytes
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // receiver backpressure: draw a hold for every result
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (out_valid) stall_left = busy_mode ? $urandom_range(0, 17) : 0;
    end
  end

  task automatic push(logic [1:0] act, logic [7:0] rxb, logic [5:0] cmd);
    int gap;
    gap = busy_mode ? $urandom_range(0, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{action: act, rx_byte: rxb, command: cmd};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
  endtask

  task automatic ticks(int n);
    repeat (n) push(tulc_pkg::ACT_TICK, 8'($urandom), 6'($urandom));
  endtask

  task automatic reply(logic [7:0] status, logic [7:0] code, bit corrupt);
    logic [7:0] sum;
    sum = tulc_pkg::FRAME_START + status + code;
    if (corrupt) sum = sum ^ 8'(1 << $urandom_range(0, 7));
    push(tulc_pkg::ACT_RX, tulc_pkg::FRAME_START, 6'($urandom));
    push(tulc_pkg::ACT_RX, status, 6'($urandom));
    push(tulc_pkg::ACT_RX, code, 6'($urandom));
    push(tulc_pkg::ACT_RX, sum, 6'($urandom));
  endtask

  // hold stimulus until every result is back, then let the pipe drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] st, logic [15:0] gp, logic [7:0] txto,
                          logic [7:0] rxto, logic [15:0] lost, logic [15:0] first);
    logic [15:0] vals[6];
    vals = '{st, gp, 16'(txto), 16'(rxto), lost, first};
    settle();
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    n_phases++;
  endtask

  task automatic random_traffic(int n);
    int pick, target;
    logic [7:0] code;
    target = n_items + n;
    while (n_items < target) begin
      busy_mode = ($urandom_range(0, 19) != 0);
      pick = $urandom_range(0, 11);
      case (pick)
        0, 1, 2: begin
          case ($urandom_range(0, 5))
            0: push(tulc_pkg::ACT_QUEUE, 8'($urandom), tulc_pkg::TYPE_QUERY);
            1: push(tulc_pkg::ACT_QUEUE, 8'($urandom), tulc_pkg::MUTE_INDEX);
            2: push(tulc_pkg::ACT_QUEUE, 8'($urandom), 6'($urandom));
            default: push(tulc_pkg::ACT_QUEUE, 8'($urandom), 6'($urandom_range(0, 39)));
          endcase
        end
        3, 4: ticks($urandom_range(1, 6));
        5: repeat ($urandom_range(1, 6))
             push(tulc_pkg::ACT_READY, 8'($urandom), 6'($urandom));
        6, 7, 8: begin
          code = $urandom_range(0, 1) ?
                 8'($urandom_range(tulc_pkg::TYPE_LOW, tulc_pkg::TYPE_MUTED)) : 8'($urandom);
          reply(8'($urandom), code, $urandom_range(0, 9) == 0);
          if ($urandom_range(0, 1)) ticks(1);
        end
        9: begin
          // broken frame: start and at most two more bytes, then silence
          push(tulc_pkg::ACT_RX, tulc_pkg::FRAME_START, 6'($urandom));
          repeat ($urandom_range(0, 2)) push(tulc_pkg::ACT_RX, 8'($urandom), 6'($urandom));
          ticks($urandom_range(1, 12));
        end
        10: push(tulc_pkg::ACT_RX, 8'($urandom), 6'($urandom));
        default: push(2'($urandom), 8'($urandom), 6'($urandom));
      endcase
    end
    busy_mode = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: long startup, so only queueing and reply capture happen
    push(tulc_pkg::ACT_QUEUE, 8'h00, 6'd0);
    push(tulc_pkg::ACT_QUEUE, 8'hFF, tulc_pkg::TYPE_QUERY);
    push(tulc_pkg::ACT_QUEUE, 8'h00, 6'd40);
    push(tulc_pkg::ACT_QUEUE, 8'h00, 6'd63);
    push(tulc_pkg::ACT_QUEUE, 8'h00, tulc_pkg::MUTE_INDEX);
    push(tulc_pkg::ACT_READY, 8'h00, 6'd0);
    reply(8'h00, 8'h00, 1'b0);
    reply(8'hFF, 8'hFF, 1'b0);
    ticks(2);
    push(tulc_pkg::ACT_RX, 8'hFF, 6'h3F);
    push(tulc_pkg::ACT_RX, 8'h00, 6'h00);
    ticks(2);

    // fast settings: drain the queue, send frames, take the type reply
    set_regs(16'd0, 16'd2, 8'd6, 8'd3, 16'd30, 16'd10);
    ticks(3);
    repeat (5) push(tulc_pkg::ACT_READY, 8'h00, 6'd0);
    reply(8'h80, tulc_pkg::TYPE_MUTED, 1'b0);
    ticks(3);
    push(tulc_pkg::ACT_QUEUE, 8'h00, tulc_pkg::MUTE_INDEX);
    random_traffic(200);

    // low extremes
    set_regs(16'd0, 16'd0, 8'd1, 8'd1, 16'd1, 16'd1);
    random_traffic(150);

    // high extremes: nothing is sent, the command queue fills up
    set_regs(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    repeat (70) push(tulc_pkg::ACT_QUEUE, 8'($urandom), 6'($urandom_range(0, 39)));
    random_traffic(80);

    // moderate settings: the full queue drains through real frames
    set_regs(16'd3, 16'd5, 8'd10, 8'd8, 16'd40, 16'd100);
    random_traffic(150);
    settle();
    random_traffic(150);

    settle();
    repeat (20) @(posedge clk);
    $display("run covered %0d input transactions over %0d register settings", n_items, n_phases);
    $display("%0d frame bytes sent, %0d replies consumed", n_tx_bytes, n_replies);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
